// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/alsu_pkg.sv -----
// ---------------------------------------------------------------------------
// Axis limit supervisor package
// Types, codes and constants shared by the supervisor and its channels.
// ---------------------------------------------------------------------------
package alsu_pkg;

   localparam int OPCODE_W   = 4;
   localparam int POS_W      = 32;
   localparam int SPEED_W    = 8;
   localparam int LED_W      = 6;
   localparam int SEL_W      = 2;
   localparam int MARGIN_W   = 31;
   localparam int MILLIS_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_STEP      = 4'd0,
      OP_ZERO_HERE = 4'd1,
      OP_CAPTURE   = 4'd2,
      OP_LOAD_POS  = 4'd3,
      OP_WRITE_LIM = 4'd4,
      OP_RESET_POS = 4'd5,
      OP_SELECT    = 4'd6,
      OP_SPEED     = 4'd7,
      OP_REPORT    = 4'd8
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE        = 2'd0,
      CSR_ZERO_MARGIN = 2'd1,
      CSR_MIN_UNSET   = 2'd2,
      CSR_MAX_UNSET   = 2'd3
   } csr_index_type;

   // Limit selection codes; code three is not a selection.
   localparam logic [SEL_W-1:0] SEL_NONE    = 2'd0;
   localparam logic [SEL_W-1:0] SEL_MIN     = 2'd1;
   localparam logic [SEL_W-1:0] SEL_MAX     = 2'd2;
   localparam logic [SEL_W-1:0] SEL_INVALID = 2'd3;

   localparam logic                    MODE_RUN          = 1'b0;
   localparam logic                    MODE_CALIB        = 1'b1;
   localparam logic                    MODE_RESET        = 1'b0;
   localparam logic [MARGIN_W-1:0]     ZERO_MARGIN_RESET = 31'd10;
   localparam logic signed [POS_W-1:0] MIN_UNSET_RESET   = 32'sh8000_0000;
   localparam logic signed [POS_W-1:0] MAX_UNSET_RESET   = 32'sh7FFF_FFFF;

   // Blink timing in milliseconds.
   localparam int SLOW_PERIOD   = 1000;
   localparam int SLOW_ON_AFTER = 500;
   localparam int FAST_PERIOD   = 500;
   localparam int FAST_ON_AFTER = 250;

   // floor(2^32 / 1000); the quotient estimate is low by at most one.
   localparam int                RECIP_W    = 23;
   localparam logic [RECIP_W-1:0] SLOW_RECIP = 23'd4294967;
   localparam int                REM_W      = 11;

   localparam int SPEED_DIV_SLOW  = 10;
   localparam int SPEED_DIV_CALIB = 4;

   typedef struct packed {
      logic [OPCODE_W-1:0]        opcode;
      logic                       step_ccw;
      logic signed [POS_W-1:0]    value;
      logic                       limit_is_min;
      logic [SEL_W-1:0]           limit_select;
      logic signed [SPEED_W-1:0]  speed_demand;
      logic [MILLIS_W-1:0]        millis_now;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]    position_now;
      logic signed [SPEED_W-1:0]  speed_allowed;
      logic [LED_W-1:0]           leds;
      logic                       at_zero;
      logic                       axis_zeroed;
      logic [SEL_W-1:0]           selection_now;
      logic signed [POS_W-1:0]    minimum_now;
      logic signed [POS_W-1:0]    maximum_now;
      logic                       status;
   } rsp_type;

   typedef struct packed {
      csr_index_type              index;
      logic [CSR_DATA_W-1:0]      wdata;
   } csr_type;

endpackage

// ----- rtl/alsu_chan_if.sv -----
// ---------------------------------------------------------------------------
// Supervisor channel interface
// Valid/ready channel carrying one payload word per handshake.
// ---------------------------------------------------------------------------
interface alsu_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/axis_limit_supervisor.sv -----
// ---------------------------------------------------------------------------
// Axis limit supervisor
// Tracks one axis position against its limits and checks the speed demand.
// ---------------------------------------------------------------------------
// Usage:
// req_if carries one command word per handshake (step, zero, capture, load,
// write limit, reset, select, speed or report). rsp_if returns exactly one
// status word for each command: position, allowed speed, LEDs, flags and
// both limits as they stand after the command.
// csr_if writes the mode, zero margin and the two unset limit markers; it is
// always ready. It must be written only while no command is in flight;
// the block does not enforce this. A command is registered in the command
// stage, then its response in the response register. A new command is
// accepted every cycle unless the receiver stalls. The millisecond
// remainder needs a reciprocal multiply, so the command stage registers the
// quotient estimate and the state update happens in the second stage.
// When the receiver stalls, the response register holds its word and the
// command stage holds one more; req_if.ready drops once both are full.
// Reset is synchronous: registers return to their reset values, the axis
// is at position 0, unzeroed, with no limit selected and both limits unset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module axis_limit_supervisor (
   input  logic        clock,
   input  logic        reset,
   alsu_chan_if.sink   req_if,
   alsu_chan_if.source rsp_if,
   alsu_chan_if.sink   csr_if
);

   // Configuration registers.
   logic                                      mode_ff;
   logic [alsu_pkg::MARGIN_W-1:0]             margin_ff;
   logic signed [alsu_pkg::POS_W-1:0]         min_unset_ff;
   logic signed [alsu_pkg::POS_W-1:0]         max_unset_ff;

   // Axis state.
   logic signed [alsu_pkg::POS_W-1:0]         position_ff, position_in;
   logic signed [alsu_pkg::POS_W-1:0]         lower_ff, lower_in;
   logic signed [alsu_pkg::POS_W-1:0]         upper_ff, upper_in;
   logic                                      zeroed_ff, zeroed_in;
   logic [alsu_pkg::SEL_W-1:0]                choice_ff, choice_in;
   logic signed [alsu_pkg::SPEED_W-1:0]       speed_ff, speed_in;

   // Command stage.
   logic                                      s1_valid_ff;
   alsu_pkg::req_type                         s1_req_ff;
   logic [alsu_pkg::RECIP_W-1:0]              s1_quot_ff;
   logic [alsu_pkg::MILLIS_W+alsu_pkg::RECIP_W-1:0] recip_prod;

   // Response stage.
   logic                                      rsp_valid_ff;
   alsu_pkg::rsp_type                         rsp_data_ff, rsp_data_in;

   logic                                      out_load;
   logic                                      s1_load;
   logic                                      cmd_fire;

   // Derived per-command values.
   logic [alsu_pkg::REM_W-1:0]                quot_times_period;
   logic [alsu_pkg::REM_W-1:0]                rem_est;
   logic [alsu_pkg::REM_W-1:0]                rem_slow;
   logic [alsu_pkg::REM_W-1:0]                rem_fast;
   logic                                      blink1, blink2;
   logic                                      below, above, in_range, at_zero;
   logic signed [alsu_pkg::POS_W:0]           pos_wide;
   logic signed [alsu_pkg::POS_W:0]           margin_wide;
   logic                                      allowed;
   logic signed [alsu_pkg::SPEED_W-1:0]       speed_out;
   logic                                      status;
   logic [alsu_pkg::LED_W-1:0]                leds;

   function automatic logic signed [alsu_pkg::SPEED_W-1:0] div10_trunc(
      input logic signed [alsu_pkg::SPEED_W-1:0] d
   );
      logic [alsu_pkg::SPEED_W-1:0]        mag;
      logic [2*alsu_pkg::SPEED_W-1:0]      prod;
      logic signed [alsu_pkg::SPEED_W-1:0] q;
      // 205 / 2048 is close enough to 1/10 for magnitudes up to 128.
      mag  = d[alsu_pkg::SPEED_W-1] ? alsu_pkg::SPEED_W'(-d) : alsu_pkg::SPEED_W'(d);
      prod = (2*alsu_pkg::SPEED_W)'(mag) * 16'd205;
      q    = alsu_pkg::SPEED_W'(prod[2*alsu_pkg::SPEED_W-1:11]);
      return d[alsu_pkg::SPEED_W-1] ? -q : q;
   endfunction

   function automatic logic signed [alsu_pkg::SPEED_W-1:0] div4_trunc(
      input logic signed [alsu_pkg::SPEED_W-1:0] d
   );
      logic [alsu_pkg::SPEED_W-1:0]        mag;
      logic signed [alsu_pkg::SPEED_W-1:0] q;
      mag = d[alsu_pkg::SPEED_W-1] ? alsu_pkg::SPEED_W'(-d) : alsu_pkg::SPEED_W'(d);
      q   = alsu_pkg::SPEED_W'(mag >> 2);
      return d[alsu_pkg::SPEED_W-1] ? -q : q;
   endfunction

   // ---------------- handshake ----------------
   assign out_load      = !rsp_valid_ff || rsp_if.ready;
   assign cmd_fire      = s1_valid_ff && out_load;
   assign req_if.ready  = !s1_valid_ff || out_load;
   assign s1_load       = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = rsp_data_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= alsu_pkg::MODE_RESET;
         margin_ff    <= alsu_pkg::ZERO_MARGIN_RESET;
         min_unset_ff <= alsu_pkg::MIN_UNSET_RESET;
         max_unset_ff <= alsu_pkg::MAX_UNSET_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.data.index)
            alsu_pkg::CSR_MODE:        mode_ff      <= csr_if.data.wdata[0];
            alsu_pkg::CSR_ZERO_MARGIN: margin_ff    <= csr_if.data.wdata[alsu_pkg::MARGIN_W-1:0];
            alsu_pkg::CSR_MIN_UNSET:   min_unset_ff <= $signed(csr_if.data.wdata);
            alsu_pkg::CSR_MAX_UNSET:   max_unset_ff <= $signed(csr_if.data.wdata);
            default: ;
         endcase
      end
   end

   // ---------------- command stage ----------------
   assign recip_prod = (alsu_pkg::MILLIS_W+alsu_pkg::RECIP_W)'(req_if.data.millis_now)
                     * (alsu_pkg::MILLIS_W+alsu_pkg::RECIP_W)'(alsu_pkg::SLOW_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff  <= req_if.data;
         s1_quot_ff <= recip_prod[alsu_pkg::MILLIS_W+alsu_pkg::RECIP_W-1:alsu_pkg::MILLIS_W];
      end
   end

   // ---------------- blink phases ----------------
   // The remainder is below twice the period, so eleven bits suffice and a
   // single subtract corrects the low quotient estimate.
   always_comb begin
      quot_times_period = alsu_pkg::REM_W'(s1_quot_ff[alsu_pkg::REM_W-1:0]
                                          * alsu_pkg::REM_W'(alsu_pkg::SLOW_PERIOD));
      rem_est  = s1_req_ff.millis_now[alsu_pkg::REM_W-1:0] - quot_times_period;
      rem_slow = (rem_est >= alsu_pkg::REM_W'(alsu_pkg::SLOW_PERIOD))
               ? rem_est - alsu_pkg::REM_W'(alsu_pkg::SLOW_PERIOD) : rem_est;
      rem_fast = (rem_slow >= alsu_pkg::REM_W'(alsu_pkg::FAST_PERIOD))
               ? rem_slow - alsu_pkg::REM_W'(alsu_pkg::FAST_PERIOD) : rem_slow;
      blink1   = rem_slow > alsu_pkg::REM_W'(alsu_pkg::SLOW_ON_AFTER);
      blink2   = rem_fast > alsu_pkg::REM_W'(alsu_pkg::FAST_ON_AFTER);
   end

   // ---------------- state update ----------------
   always_comb begin
      position_in = position_ff;
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      zeroed_in   = zeroed_ff;
      choice_in   = choice_ff;
      speed_in    = speed_ff;
      status      = 1'b0;
      unique case (alsu_pkg::opcode_type'(s1_req_ff.opcode))
         alsu_pkg::OP_STEP: begin
            position_in = s1_req_ff.step_ccw ? position_ff + 32'sd1 : position_ff - 32'sd1;
         end
         alsu_pkg::OP_ZERO_HERE: begin
            position_in = '0;
            zeroed_in   = 1'b1;
         end
         alsu_pkg::OP_CAPTURE: begin
            if (!zeroed_ff) begin
               status = 1'b1;
            end else if (choice_ff == alsu_pkg::SEL_MAX) begin
               upper_in = position_ff;
            end else if (choice_ff == alsu_pkg::SEL_MIN) begin
               lower_in = position_ff;
            end
         end
         alsu_pkg::OP_LOAD_POS: begin
            position_in = s1_req_ff.value;
         end
         alsu_pkg::OP_WRITE_LIM: begin
            if (s1_req_ff.limit_is_min) begin
               lower_in = s1_req_ff.value;
            end else begin
               upper_in = s1_req_ff.value;
            end
         end
         alsu_pkg::OP_RESET_POS: begin
            lower_in    = min_unset_ff;
            upper_in    = max_unset_ff;
            position_in = '0;
         end
         alsu_pkg::OP_SELECT: begin
            if (s1_req_ff.limit_select != alsu_pkg::SEL_INVALID) begin
               choice_in = s1_req_ff.limit_select;
            end
         end
         alsu_pkg::OP_SPEED: begin
            speed_in = s1_req_ff.speed_demand;
         end
         default: ;
      endcase
   end

   // ---------------- report ----------------
   always_comb begin
      below       = position_in <= lower_in;
      above       = position_in >= upper_in;
      in_range    = !below && !above;
      pos_wide    = {position_in[alsu_pkg::POS_W-1], position_in};
      margin_wide = $signed({2'b00, margin_ff});
      at_zero     = (pos_wide <= margin_wide) && (pos_wide >= -margin_wide);

      allowed = in_range
             || (below && !speed_in[alsu_pkg::SPEED_W-1] && (speed_in != '0))
             || (above && speed_in[alsu_pkg::SPEED_W-1]);

      if (!zeroed_in) begin
         speed_out = div10_trunc(speed_in);
      end else if (mode_ff == alsu_pkg::MODE_RUN) begin
         speed_out = allowed ? speed_in : '0;
      end else begin
         speed_out = allowed ? div4_trunc(speed_in) : div10_trunc(speed_in);
      end

      leds = '0;
      if (mode_ff == alsu_pkg::MODE_RUN) begin
         leds[0] = (lower_in == min_unset_ff) ? blink2 : below;
         leds[1] = (upper_in == max_unset_ff) ? blink2 : above;
         leds[2] = !zeroed_in ? blink2 : (at_zero ? blink1 : in_range);
         leds[3] = blink2;
      end else begin
         leds[0] = (choice_in == alsu_pkg::SEL_MIN) ? (below ^ blink1) : below;
         leds[1] = (choice_in == alsu_pkg::SEL_MAX) ? (above ^ blink1) : above;
         leds[2] = in_range;
         leds[3] = blink1;
      end

      rsp_data_in.position_now  = position_in;
      rsp_data_in.speed_allowed = speed_out;
      rsp_data_in.leds          = leds;
      rsp_data_in.at_zero       = at_zero;
      rsp_data_in.axis_zeroed   = zeroed_in;
      rsp_data_in.selection_now = choice_in;
      rsp_data_in.minimum_now   = lower_in;
      rsp_data_in.maximum_now   = upper_in;
      rsp_data_in.status        = status;
   end

   // ---------------- state and response registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         lower_ff    <= alsu_pkg::MIN_UNSET_RESET;
         upper_ff    <= alsu_pkg::MAX_UNSET_RESET;
         zeroed_ff   <= 1'b0;
         choice_ff   <= alsu_pkg::SEL_NONE;
         speed_ff    <= '0;
      end else if (cmd_fire) begin
         position_ff <= position_in;
         lower_ff    <= lower_in;
         upper_ff    <= upper_in;
         zeroed_ff   <= zeroed_in;
         choice_ff   <= choice_in;
         speed_ff    <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- assertions ----------------
   `ASSERT_IMPLIES(a_status_unzeroed, clock, reset,
      rsp_if.valid && rsp_if.data.status, !rsp_if.data.axis_zeroed,
      "capture rejection reported on a zeroed axis")
   `ASSERT_IMPLIES(a_selection_code, clock, reset,
      rsp_if.valid, rsp_if.data.selection_now != alsu_pkg::SEL_INVALID,
      "invalid limit selection reported")
   `ASSERT_IMPLIES(a_motion_leds_dark, clock, reset,
      rsp_if.valid, rsp_if.data.leds[5:4] == 2'b00,
      "motion LEDs driven")
   `ASSERT_NEXT(a_cmd_stage_hold, clock, reset,
      s1_valid_ff && !out_load, s1_valid_ff && $stable(s1_req_ff),
      "command stage lost its word during a stall")

endmodule
